/* sv/lirs_pkg.sv */
// shared types and constants of the linear interpolation resampler
`default_nettype none

package lirs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 18;
    localparam int PH_W       = 19;
    localparam int ACC_W      = 38;
    localparam int QUO_W      = 37;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_INPUT_RATE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_RATE = 1'b1;

    localparam logic [RATE_W-1:0] RESET_INPUT_RATE  = 18'd24000;
    localparam logic [RATE_W-1:0] RESET_OUTPUT_RATE = 18'd16000;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic latch_in;
        logic set_marker;
        logic clear_payload;
        logic first_sample;
        logic load_phase;
        logic mul;
        logic sum;
        logic finish;
        logic end_pair;
        logic push;
    } lirs_cmd_t;

    typedef struct packed {
        logic rate_err;
        logic first_seen;
        logic last;
        logic loop_go;
        logic none_out;
        logic div_done;
        logic pend_has;
        logic out_free;
    } lirs_stat_t;

endpackage

`default_nettype wire

/* sv/lirs_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module lirs_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lirs_pkg::QUO_W-1:0]  dividend,
    input  wire logic [lirs_pkg::RATE_W-1:0] divisor,
    output logic                             done,
    output logic [lirs_pkg::QUO_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(lirs_pkg::QUO_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [lirs_pkg::RATE_W-1:0] rem_reg;
    logic [lirs_pkg::QUO_W-1:0]  quo_reg;

    logic [lirs_pkg::RATE_W:0]   rem_shift;
    logic                        bit_next;
    logic [lirs_pkg::RATE_W:0]   rem_sub;
    logic [lirs_pkg::RATE_W-1:0] rem_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[lirs_pkg::QUO_W-1]};
        bit_next  = rem_shift >= {1'b0, divisor};
        rem_sub   = rem_shift - {1'b0, divisor};
        rem_next  = bit_next ? rem_sub[lirs_pkg::RATE_W-1:0]
                             : rem_shift[lirs_pkg::RATE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                cnt_reg  <= CNT_W'(lirs_pkg::QUO_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[lirs_pkg::QUO_W-2:0], bit_next};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/lirs_dp.sv */
// datapath: rate registers, payload state, products, divider and output stage
`default_nettype none

module lirs_dp #(
    parameter int MAX_UPSAMPLE = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [lirs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lirs_pkg::RATE_W-1:0]     cfg_wdata,
    input  wire logic [15:0]                     s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,
    output logic                                 m_tlast,
    output logic [1:0]                           m_tuser,
    input  wire lirs_pkg::lirs_cmd_t             cmd,
    output lirs_pkg::lirs_stat_t                 stat
);

    localparam int SW = lirs_pkg::SAMPLE_W;
    localparam int RW = lirs_pkg::RATE_W;
    localparam int PW = lirs_pkg::PH_W;
    localparam int AW = lirs_pkg::ACC_W;
    localparam int QW = lirs_pkg::QUO_W;
    localparam int NW = $clog2(2 * MAX_UPSAMPLE + 1);
    localparam int MW = RW + $clog2(MAX_UPSAMPLE + 1);

    logic [RW-1:0]        inr_reg;
    logic [RW-1:0]        outr_reg;
    logic signed [SW-1:0] cur_reg;
    logic                 last_reg;
    logic signed [SW-1:0] prev_reg;
    logic                 first_reg;
    logic [PW-1:0]        phase_reg;
    logic                 pair_reg;
    logic [PW-1:0]        ph_reg;
    logic [NW-1:0]        n_reg;
    logic signed [AW-1:0] prod_a_reg;
    logic signed [AW-1:0] prod_b_reg;
    logic                 neg_reg;
    logic signed [SW-1:0] pend_sample_reg;
    logic                 pend_has_reg;
    logic                 pend_err_reg;
    logic                 out_valid_reg;
    logic [SW-1:0]        out_sample_reg;
    logic                 out_last_reg;
    logic                 out_has_reg;
    logic                 out_err_reg;

    logic [MW-1:0]          max_out;
    logic                   rate_err;
    logic [PW:0]            ph_plus;
    logic [PW:0]            twice_outr;
    logic                   cond_more;
    logic                   cond_tail;
    logic                   loop_go;
    logic signed [SW:0]     diff;
    logic signed [AW-2:0]   prod_b_full;
    logic signed [SW+RW:0]  prod_a_full;
    logic signed [AW-1:0]   acc;
    logic                   acc_neg;
    logic [AW-1:0]          acc_mag;
    logic                   div_done;
    logic [QW-1:0]          quotient;
    logic [SW:0]            neg_val;
    logic signed [SW-1:0]   sample_next;
    logic                   out_free;

    always_comb begin
        max_out  = MW'(inr_reg) * MW'(MAX_UPSAMPLE);
        rate_err = (inr_reg == '0) || (outr_reg == '0) || (MW'(outr_reg) > max_out);

        ph_plus    = {1'b0, ph_reg} + {2'b0, inr_reg};
        twice_outr = {1'b0, outr_reg, 1'b0};
        cond_more  = (ph_reg < {1'b0, outr_reg}) && (n_reg < NW'(MAX_UPSAMPLE));
        cond_tail  = (n_reg < NW'(2 * MAX_UPSAMPLE)) &&
                     ((ph_plus <= twice_outr) || (!pair_reg && (n_reg == '0)));
        loop_go    = last_reg ? cond_tail : cond_more;

        diff        = {cur_reg[SW-1], cur_reg} - {prev_reg[SW-1], prev_reg};
        prod_b_full = diff * $signed({1'b0, ph_reg});
        prod_a_full = prev_reg * $signed({1'b0, outr_reg});

        acc     = prod_a_reg + prod_b_reg;
        acc_neg = acc[AW-1];
        acc_mag = acc_neg ? (-acc) : acc;

        neg_val = -quotient[SW:0];
        if (neg_reg) begin
            sample_next = (quotient > QW'(32768)) ? lirs_pkg::SAT_MIN
                                                  : $signed(neg_val[SW-1:0]);
        end else begin
            sample_next = (quotient > QW'(32767)) ? lirs_pkg::SAT_MAX
                                                  : $signed(quotient[SW-1:0]);
        end

        out_free = !out_valid_reg || m_tready;
    end

    lirs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sum),
        .dividend (acc_mag[QW-1:0]),
        .divisor  (outr_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inr_reg       <= lirs_pkg::RESET_INPUT_RATE;
            outr_reg      <= lirs_pkg::RESET_OUTPUT_RATE;
            prev_reg      <= '0;
            first_reg     <= 1'b0;
            phase_reg     <= '0;
            pair_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    lirs_pkg::REG_INPUT_RATE:  inr_reg  <= cfg_wdata;
                    lirs_pkg::REG_OUTPUT_RATE: outr_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (cmd.latch_in) begin
                cur_reg  <= $signed(s_tdata);
                last_reg <= s_tlast;
            end

            if (cmd.clear_payload) begin
                prev_reg  <= '0;
                first_reg <= 1'b0;
                phase_reg <= '0;
                pair_reg  <= 1'b0;
            end else if (cmd.first_sample) begin
                prev_reg  <= cur_reg;
                first_reg <= 1'b1;
                phase_reg <= '0;
                pair_reg  <= 1'b0;
            end else if (cmd.end_pair) begin
                prev_reg  <= cur_reg;
                phase_reg <= (ph_reg >= {1'b0, outr_reg}) ? (ph_reg - {1'b0, outr_reg}) : '0;
                pair_reg  <= 1'b1;
            end

            if (cmd.load_phase) begin
                ph_reg <= phase_reg;
                n_reg  <= '0;
            end else if (cmd.finish) begin
                ph_reg <= ph_plus[PW-1:0];
                n_reg  <= n_reg + 1'b1;
            end

            if (cmd.mul) begin
                prod_a_reg <= {{(AW - SW - RW - 1){prod_a_full[SW+RW]}}, prod_a_full};
                prod_b_reg <= {prod_b_full[AW-2], prod_b_full};
            end
            if (cmd.sum) begin
                neg_reg <= acc_neg;
            end

            if (cmd.set_marker) begin
                pend_sample_reg <= '0;
                pend_has_reg    <= 1'b0;
                pend_err_reg    <= rate_err;
            end else if (cmd.finish) begin
                pend_sample_reg <= sample_next;
                pend_has_reg    <= 1'b1;
                pend_err_reg    <= 1'b0;
            end

            if (cmd.push) begin
                out_valid_reg  <= 1'b1;
                out_sample_reg <= pend_sample_reg;
                out_has_reg    <= pend_has_reg;
                out_err_reg    <= pend_err_reg;
                out_last_reg   <= last_reg && (!pend_has_reg || !loop_go);
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.rate_err   = rate_err;
        stat.first_seen = first_reg;
        stat.last       = last_reg;
        stat.loop_go    = loop_go;
        stat.none_out   = (n_reg == '0);
        stat.div_done   = div_done;
        stat.pend_has   = pend_has_reg;
        stat.out_free   = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_err_reg, out_has_reg};

endmodule

`default_nettype wire

/* sv/lirs_ctrl.sv */
// controller state machine sequencing the per-sample work
`default_nettype none

module lirs_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire lirs_pkg::lirs_stat_t  stat,
    output lirs_pkg::lirs_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOOP,
        S_SUM,
        S_DIV,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.rate_err) begin
                    cmd.set_marker    = 1'b1;
                    cmd.clear_payload = 1'b1;
                    state_next        = S_PUSH;
                end else if (!stat.first_seen) begin
                    if (stat.last) begin
                        cmd.set_marker    = 1'b1;
                        cmd.clear_payload = 1'b1;
                        state_next        = S_PUSH;
                    end else begin
                        cmd.first_sample = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else begin
                    cmd.load_phase = 1'b1;
                    state_next     = S_LOOP;
                end
            end
            S_LOOP: begin
                if (stat.loop_go) begin
                    cmd.mul    = 1'b1;
                    state_next = S_SUM;
                end else if (stat.last) begin
                    cmd.clear_payload = 1'b1;
                    if (stat.none_out) begin
                        cmd.set_marker = 1'b1;
                        state_next     = S_PUSH;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.end_pair = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.finish = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = stat.pend_has ? S_LOOP : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

/* sv/linear_interp_pcm_resampler.sv */
// top level: linear interpolation pcm resampler
// a sample beat that yields no result skips the product, sum and divider steps; each result
// goes through a product step, a sum step, the divider's 37 quotient bits, a step to see the
// divider finish and an output load, which waits while the output stalls
// the shared bit-serial divider sets the rate; one sample beat is in work at a time
// synchronous active-low reset: rates return to 24000 and 16000, payload state clears
`default_nettype none

module linear_interp_pcm_resampler #(
    parameter int MAX_UPSAMPLE = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [lirs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lirs_pkg::RATE_W-1:0]     cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // sample_in
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,   // sample_out
    output logic                                 m_tlast,
    output logic [1:0]                           m_tuser    // bit 1 rate_error, bit 0 has_sample
);

    lirs_pkg::lirs_cmd_t  cmd;
    lirs_pkg::lirs_stat_t stat;

    lirs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lirs_dp #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

/* verif/tb_linear_interp_pcm_resampler.sv */
// testbench for the linear interpolation resampler: directed and random payloads
`default_nettype none

module tb_linear_interp_pcm_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_UP    = 8;
    localparam int HALF_NS   = 2;
    localparam int SETTLE    = 64;
    localparam int WATCHDOG  = 4000;
    localparam int SHOW_MAX  = 10;
    localparam int USR_HAS   = 0;
    localparam int USR_ERR   = 1;

    typedef struct {
        logic signed [lirs_pkg::SAMPLE_W-1:0] smp;
        logic                                 fin;
    } pcm_beat_t;

    typedef struct {
        logic signed [lirs_pkg::SAMPLE_W-1:0] smp;
        logic                                 has;
        logic                                 fin;
        logic                                 err;
    } resamp_res_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [lirs_pkg::CFG_ADDR_W-1:0] cfg_addr = lirs_pkg::REG_INPUT_RATE;
    logic [lirs_pkg::RATE_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [15:0]                     m_tdata;
    logic                            m_tlast;
    logic [1:0]                      m_tuser;

    pcm_beat_t   beat_q[$];
    resamp_res_t want_q[$];

    // predictor state
    logic [lirs_pkg::RATE_W-1:0]          in_hz = lirs_pkg::RESET_INPUT_RATE;
    logic [lirs_pkg::RATE_W-1:0]          out_hz = lirs_pkg::RESET_OUTPUT_RATE;
    logic signed [lirs_pkg::SAMPLE_W-1:0] hold_smp = '0;
    logic                                 have_first = 1'b0;
    logic [lirs_pkg::PH_W-1:0]            frac_pos = '0;
    logic                                 pair_seen = 1'b0;

    bit in_took;
    bit gaps_on = 1'b1;
    int in_gap;
    int out_gap;
    int quiet;
    int errs;
    int beats_in;
    int res_seen;
    int settings;

    linear_interp_pcm_resampler #(
        .MAX_UPSAMPLE(MAX_UP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(HALF_NS) aclk = ~aclk;

    function automatic void add_result(logic signed [lirs_pkg::SAMPLE_W-1:0] smp,
                                       logic has, logic fin, logic err);
        resamp_res_t r;
        r.smp = smp;
        r.has = has;
        r.fin = fin;
        r.err = err;
        want_q.insert(want_q.size(), r);
    endfunction

    function automatic void drop_payload();
        hold_smp = '0;
        have_first = 1'b0;
        frac_pos = '0;
        pair_seen = 1'b0;
    endfunction

    function automatic logic signed [lirs_pkg::SAMPLE_W-1:0] blend(
        logic signed [lirs_pkg::SAMPLE_W-1:0] a,
        logic signed [lirs_pkg::SAMPLE_W-1:0] b,
        longint r, longint den);
        longint num;
        longint q;
        num = longint'(a) * (den - r) + longint'(b) * r;
        q = num / den;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    function automatic void resample_beat(logic signed [lirs_pkg::SAMPLE_W-1:0] smp,
                                          logic fin);
        longint ph;
        longint inr;
        longint outr;
        int     n;
        inr = in_hz;
        outr = out_hz;
        ph = frac_pos;
        n = 0;
        if (inr == 0 || outr == 0 || outr > MAX_UP * inr) begin
            add_result('0, 1'b0, fin, 1'b1);
            drop_payload();
            return;
        end
        if (!have_first) begin
            if (fin) begin
                add_result('0, 1'b0, 1'b1, 1'b0);
                drop_payload();
                return;
            end
            hold_smp = smp;
            have_first = 1'b1;
            frac_pos = '0;
            pair_seen = 1'b0;
            return;
        end
        if (!fin) begin
            while (ph < outr && n < MAX_UP) begin
                add_result(blend(hold_smp, smp, ph, outr), 1'b1, 1'b0, 1'b0);
                n++;
                ph += inr;
            end
            ph = (ph >= outr) ? ph - outr : 0;
            frac_pos = ph[lirs_pkg::PH_W-1:0];
            hold_smp = smp;
            pair_seen = 1'b1;
            return;
        end
        // final sample: extrapolate up to the payload end
        while (n < 2 * MAX_UP && ((ph + inr <= 2 * outr) || (!pair_seen && n == 0))) begin
            add_result(blend(hold_smp, smp, ph, outr), 1'b1, 1'b0, 1'b0);
            n++;
            ph += inr;
        end
        if (n == 0) begin
            add_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
            want_q[want_q.size()-1].fin = 1'b1;
        end
        drop_payload();
    endfunction

    function automatic void queue_beat(logic signed [lirs_pkg::SAMPLE_W-1:0] smp, logic fin);
        pcm_beat_t b;
        b.smp = smp;
        b.fin = fin;
        beat_q.insert(beat_q.size(), b);
    endfunction

    function automatic logic signed [lirs_pkg::SAMPLE_W-1:0] rand_pcm();
        case ($urandom_range(0, 7))
            0: return lirs_pkg::SAT_MAX;
            1: return lirs_pkg::SAT_MIN;
            2: return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // sender
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_took)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (beat_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= beat_q[0].smp;
                s_tlast <= beat_q[0].fin;
                if (gaps_on && $urandom_range(0, 3) == 0) begin
                    in_gap = $urandom_range(1, 10);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_gap = $urandom_range(1, 10);
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        resamp_res_t want;
        bit          out_took;
        in_took = (aresetn && s_tvalid && s_tready) === 1'b1;
        out_took = (aresetn && m_tvalid && m_tready) === 1'b1;
        if (in_took) begin
            resample_beat(s_tdata, s_tlast);
            beat_q.delete(0);
            beats_in++;
        end
        if (out_took) begin
            res_seen++;
            if (want_q.size() == 0) begin
                errs++;
                if (errs <= SHOW_MAX) begin
                    $display("unexpected result beat: data %0d last %b user %b",
                             $signed(m_tdata), m_tlast, m_tuser);
                end
            end else begin
                want = want_q[0];
                want_q.delete(0);
                if (m_tdata !== want.smp || m_tlast !== want.fin ||
                    m_tuser[USR_HAS] !== want.has || m_tuser[USR_ERR] !== want.err) begin
                    errs++;
                    if (errs <= SHOW_MAX) begin
                        $display("result %0d: expected data %0d has %b last %b err %b,",
                                 res_seen, want.smp, want.has, want.fin, want.err);
                        $display("    got data %0d has %b last %b err %b",
                                 $signed(m_tdata), m_tuser[USR_HAS], m_tlast,
                                 m_tuser[USR_ERR]);
                    end
                end
            end
        end
        if (!aresetn || in_took || out_took) begin
            quiet = 0;
        end else begin
            quiet++;
        end
    end

    initial begin
        while (quiet < WATCHDOG) @(posedge aclk);
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 WATCHDOG, want_q.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic drain();
        while (beat_q.size() != 0 || want_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_rate(logic [lirs_pkg::CFG_ADDR_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= lirs_pkg::RATE_W'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic retune(int inr, int outr);
        drain();
        write_rate(lirs_pkg::REG_INPUT_RATE, inr);
        write_rate(lirs_pkg::REG_OUTPUT_RATE, outr);
        in_hz = lirs_pkg::RATE_W'(inr);
        out_hz = lirs_pkg::RATE_W'(outr);
        settings++;
    endtask

    initial begin
        int common_hz[8] = '{8000, 11025, 16000, 22050, 24000, 32000, 44100, 48000};
        int rnd_items;
        int cnt;
        int len;
        int a;
        int b;
        bit close;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset rates: single-sample, two-sample and longer payloads
        queue_beat(16'sd0, 1'b1);
        queue_beat(lirs_pkg::SAT_MAX, 1'b0);
        queue_beat(lirs_pkg::SAT_MIN, 1'b1);
        queue_beat(lirs_pkg::SAT_MIN, 1'b0);
        queue_beat(lirs_pkg::SAT_MAX, 1'b0);
        queue_beat(16'sd0, 1'b0);
        queue_beat(16'sd1234, 1'b1);

        // maximum upsampling, extrapolation into saturation
        retune(1, 8);
        queue_beat(lirs_pkg::SAT_MIN, 1'b0);
        queue_beat(lirs_pkg::SAT_MAX, 1'b1);
        queue_beat(lirs_pkg::SAT_MAX, 1'b0);
        queue_beat(lirs_pkg::SAT_MIN, 1'b1);

        // heavy downsampling: short payload still gives its first sample, longer one ends bare
        retune(192000, 1);
        queue_beat(16'sd5, 1'b0);
        queue_beat(16'sd7, 1'b1);
        queue_beat(16'sd100, 1'b0);
        queue_beat(16'sd200, 1'b0);
        queue_beat(16'sd300, 1'b1);

        // unusable rates
        retune(24000, 0);
        queue_beat(16'sd10, 1'b1);
        retune(1000, 8001);
        queue_beat(16'sd20, 1'b0);
        queue_beat(16'sd30, 1'b1);
        retune(0, 16000);
        queue_beat(-16'sd40, 1'b1);

        // rates changed inside a payload
        retune(24000, 16000);
        queue_beat(16'sd1000, 1'b0);
        queue_beat(16'sd2000, 1'b0);
        retune(44100, 48000);
        queue_beat(16'sd3000, 1'b0);
        queue_beat(16'sd4000, 1'b1);

        rnd_items = 0;
        for (int pi = 0; pi < 12; pi++) begin
            case ($urandom_range(0, 9))
                0: begin a = 1; b = 8; end
                1: begin a = 192000; b = 192000; end
                2: begin a = 192000; b = 1; end
                3: begin a = 1; b = 1; end
                4: begin
                    a = $urandom_range(1, 20000);
                    b = 8 * a + $urandom_range(1, 1000);
                end
                5: begin
                    if ($urandom_range(0, 1) == 0) begin
                        a = 0;
                        b = $urandom_range(1, 192000);
                    end else begin
                        a = $urandom_range(1, 192000);
                        b = 0;
                    end
                end
                6, 7: begin
                    a = common_hz[$urandom_range(0, 7)];
                    b = common_hz[$urandom_range(0, 7)];
                end
                default: begin
                    a = $urandom_range(1, 192000);
                    b = $urandom_range(1, (8 * a > 192000) ? 192000 : 8 * a);
                end
            endcase
            if (pi == 11) begin
                a = 48000;
                b = 44100;
            end
            retune(a, b);
            gaps_on = (pi < 11) && ($urandom_range(0, 3) != 0);
            cnt = 0;
            while (cnt < 30) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_beat(rand_pcm(), 1'($urandom_range(0, 1)));
                    cnt++;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                    close = !(cnt + len >= 30 && pi < 11 && $urandom_range(0, 2) == 0);
                    for (int k = 0; k < len; k++) begin
                        queue_beat(rand_pcm(), close && k == len - 1);
                    end
                    cnt += len;
                end
            end
            rnd_items += cnt;
        end
        drain();

        $display("covered %0d sample beats (%0d random) under %0d rate settings",
                 beats_in, rnd_items, settings);
        $display("checked %0d result beats, %0d mismatches", res_seen, errs);
        if (errs == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
